>>> src/bpra_pkg.sv
// Shared field widths, codes and state type of the bitmap page run allocator.
package bpra_pkg;

  localparam int START_W  = 16;
  localparam int LEN_W    = 17;
  localparam int LIMIT_W  = 17;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 16;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_SRD  = 7'b0000100,
    S_SEV  = 7'b0001000,
    S_RRD  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

endpackage

>>> src/bpra_scan.sv
// Word scanner: finds the lowest used page bit inside a window of one map word.
module bpra_scan #(
  parameter int WORD_W = 32
) (
  input  logic [WORD_W-1:0]         word,
  input  logic [$clog2(WORD_W)-1:0] first_bit,
  input  logic [$clog2(WORD_W):0]   end_bit,
  output logic                      used_found,
  output logic [$clog2(WORD_W):0]   stop_bit
);

  localparam int WB = $clog2(WORD_W);

  logic [WORD_W-1:0] in_range;
  logic [WORD_W-1:0] used;
  logic [WB-1:0]     low_pos;

  // window is [first_bit, end_bit); a shift by WORD_W clears everything
  assign in_range = ({WORD_W{1'b1}} << first_bit) & ~({WORD_W{1'b1}} << end_bit);
  assign used     = word & in_range;

  always_comb begin
    low_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (used[j]) begin
        low_pos = WB'(j);
      end
    end
  end

  assign used_found = |used;
  assign stop_bit   = used_found ? {1'b0, low_pos} : end_bit;

endmodule

>>> src/bitmap_page_run_allocator_unit.sv
// Next-fit bitmap page allocator: one result per request, map held in a synchronous RAM.
// After reset an initialisation pass writes every map word to all used, one word a cycle;
// input is stalled meanwhile. Allocate: the scan reads map words and steps past each
// used page met, then each word of the granted run is read and written back marked.
// Free: each word touched is read and written back cleared. An empty free or a zero
// length allocate goes straight to the response. One request is in flight at a time;
// the result register lets the next request enter.
module bitmap_page_run_allocator_unit #(
  parameter int NUM_PAGES     = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [bpra_pkg::START_W-1:0]   start_page,
  input  logic [bpra_pkg::LEN_W-1:0]     run_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bpra_pkg::STATUS_W-1:0]  status,
  output logic [bpra_pkg::GRANT_W-1:0]   granted_page,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpra_pkg::LIMIT_W-1:0]   cfg_data
);

  import bpra_pkg::*;

  localparam int WB     = $clog2(MAP_WORD_BITS);
  localparam int WORD_W = 1 << WB;
  localparam int DEPTH  = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW     = ($clog2(NUM_PAGES + 1) > LIMIT_W) ? $clog2(NUM_PAGES + 1) : LIMIT_W;

  localparam logic [PW-1:0] NUM_PAGES_P = PW'(NUM_PAGES);
  localparam logic [PW-1:0] WORD_W_P    = PW'(WORD_W);
  localparam logic [PW-1:0] BIT_MASK_P  = PW'(WORD_W - 1);
  localparam logic [AW-1:0] LAST_WORD   = AW'(DEPTH - 1);
  localparam logic [WB-1:0] TOP_BIT     = WB'(WORD_W - 1);

  function automatic logic [AW-1:0] word_of(input logic [PW-1:0] pg);
    word_of = AW'(pg >> WB);
  endfunction

  // map storage
  logic [WORD_W-1:0] map_mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  // control registers
  state_t          state, state_next;
  logic [AW-1:0]   init_addr, init_addr_next;
  logic [LIMIT_W-1:0] page_limit;
  logic [PW-1:0]   cursor, cursor_next;
  logic            second_pass, second_pass_next;
  logic            out_valid_next;

  // working registers
  logic [PW-1:0]    cur, cur_next;
  logic [PW-1:0]    lim, lim_next;
  logic [PW-1:0]    old_cur, old_cur_next;
  logic [LEN_W-1:0] run, run_next;
  logic [LEN_W-1:0] len, len_next;
  logic [PW-1:0]    rng_lo, rng_lo_next;
  logic [PW-1:0]    rng_last, rng_last_next;
  logic             rng_set, rng_set_next;
  logic [AW-1:0]    word_idx, word_idx_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [GRANT_W-1:0]  res_grant, res_grant_next;
  logic [STATUS_W-1:0] status_next;
  logic [GRANT_W-1:0]  granted_next;

  // scan datapath
  logic [PW-1:0]    cur_base;
  logic [PW-1:0]    lim_gap;
  logic [WB:0]      end_bit;
  logic             used_found;
  logic [WB:0]      stop_bit;
  logic [WB:0]      seg_len;
  logic [WB:0]      stop_step;
  logic [LEN_W:0]   run_sum;
  logic             run_hit;
  logic [LEN_W-1:0] need;
  logic [PW-1:0]    run_end;
  logic [PW-1:0]    run_first;
  logic [PW-1:0]    skip_to;
  logic [PW-1:0]    lim_first;
  logic [PW-1:0]    lim_second;

  // free request decode
  logic [PW:0]      fr_end;
  logic             fr_over;
  logic [PW-1:0]    fr_top;
  logic             fr_empty;

  // range update datapath
  logic [WB-1:0]     lo_b;
  logic [WB-1:0]     hi_b;
  logic [WORD_W-1:0] rng_mask;
  logic [WORD_W-1:0] rng_word;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign cur_base = cur & ~BIT_MASK_P;
  assign lim_gap  = lim - cur_base;
  assign end_bit  = (lim_gap >= WORD_W_P) ? (WB + 1)'(WORD_W) : lim_gap[WB:0];

  bpra_scan #(
    .WORD_W (WORD_W)
  ) u_scan (
    .word       (rd_data),
    .first_bit  (cur[WB-1:0]),
    .end_bit    (end_bit),
    .used_found (used_found),
    .stop_bit   (stop_bit)
  );

  assign seg_len   = stop_bit - {1'b0, cur[WB-1:0]};
  assign run_sum   = {1'b0, run} + (LEN_W + 1)'(seg_len);
  assign run_hit   = (run_sum >= {1'b0, len});
  assign need      = len - run;
  assign run_end   = cur + PW'(need);
  assign run_first = run_end - PW'(len);
  assign stop_step = used_found ? (WB + 1)'(stop_bit + 1'b1) : stop_bit;
  assign skip_to   = cur_base + PW'(stop_step);

  assign lim_first  = (PW'(page_limit) > NUM_PAGES_P) ? NUM_PAGES_P : PW'(page_limit);
  assign lim_second = (old_cur > NUM_PAGES_P) ? NUM_PAGES_P : old_cur;

  // one bit wider: start plus length can run well past the page count
  assign fr_end   = (PW + 1)'(start_page) + (PW + 1)'(run_length);
  assign fr_over  = (fr_end > {1'b0, NUM_PAGES_P});
  assign fr_top   = fr_over ? NUM_PAGES_P : fr_end[PW-1:0];
  assign fr_empty = (fr_top <= PW'(start_page));

  assign lo_b     = (word_idx == word_of(rng_lo)) ? rng_lo[WB-1:0] : '0;
  assign hi_b     = (word_idx == word_of(rng_last)) ? rng_last[WB-1:0] : TOP_BIT;
  assign rng_mask = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (TOP_BIT - hi_b));
  assign rng_word = rng_set ? (rd_data | rng_mask) : (rd_data & ~rng_mask);

  always_comb begin
    state_next       = state;
    init_addr_next   = init_addr;
    cursor_next      = cursor;
    second_pass_next = second_pass;
    out_valid_next   = out_valid;
    cur_next         = cur;
    lim_next         = lim;
    old_cur_next     = old_cur;
    run_next         = run;
    len_next         = len;
    rng_lo_next      = rng_lo;
    rng_last_next    = rng_last;
    rng_set_next     = rng_set;
    word_idx_next    = word_idx;
    res_status_next  = res_status;
    res_grant_next   = res_grant;
    status_next      = status;
    granted_next     = granted_page;
    rd_en            = 1'b0;
    rd_addr          = word_of(cur);
    wr_en            = 1'b0;
    wr_addr          = word_idx;
    wr_data          = rng_word;

    // drop the result once transferred
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_INIT: begin
        wr_en          = 1'b1;
        wr_addr        = init_addr;
        wr_data        = '1;
        init_addr_next = init_addr + 1'b1;
        if (init_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_FREE: begin
              res_grant_next  = '0;
              res_status_next = fr_over ? STATUS_RANGE : STATUS_OK;
              rng_lo_next     = PW'(start_page);
              rng_last_next   = fr_top - 1'b1;
              rng_set_next    = 1'b0;
              state_next      = fr_empty ? S_RESP : S_RRD;
            end
            REQ_ALLOC: begin
              len_next         = run_length;
              run_next         = '0;
              cur_next         = cursor;
              old_cur_next     = cursor;
              lim_next         = lim_first;
              second_pass_next = 1'b0;
              res_grant_next   = '0;
              res_status_next  = STATUS_NO_RUN;
              state_next       = (run_length == '0) ? S_RESP : S_SRD;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SRD: begin
        if (cur >= lim) begin
          if (second_pass) begin
            state_next = S_RESP;
          end else begin
            // wrap: restart at page 0 up to the old cursor
            second_pass_next = 1'b1;
            cur_next         = '0;
            run_next         = '0;
            lim_next         = lim_second;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = word_of(cur);
          state_next = S_SEV;
        end
      end
      S_SEV: begin
        if (run_hit) begin
          cursor_next     = run_end;
          res_status_next = STATUS_OK;
          res_grant_next  = GRANT_W'(run_first);
          rng_lo_next     = run_first;
          rng_last_next   = run_end - 1'b1;
          rng_set_next    = 1'b1;
          state_next      = S_RRD;
        end else begin
          run_next = used_found ? '0 : run_sum[LEN_W-1:0];
          cur_next = skip_to;
          if (skip_to < lim) begin
            // fetch the next word when the scan crosses a word boundary
            if (skip_to[WB-1:0] == '0) begin
              rd_en   = 1'b1;
              rd_addr = word_of(skip_to);
            end
          end else begin
            state_next = S_SRD;
          end
        end
      end
      S_RRD: begin
        rd_en         = 1'b1;
        rd_addr       = word_of(rng_lo);
        word_idx_next = word_of(rng_lo);
        state_next    = S_WR;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = word_idx;
        wr_data = rng_word;
        if (word_idx == word_of(rng_last)) begin
          state_next = S_RESP;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = word_idx + 1'b1;
          word_idx_next = word_idx + 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          granted_next   = res_grant;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_addr   <= '0;
      page_limit  <= '0;
      cursor      <= '0;
      second_pass <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      init_addr   <= init_addr_next;
      cursor      <= cursor_next;
      second_pass <= second_pass_next;
      out_valid   <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        page_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur          <= cur_next;
    lim          <= lim_next;
    old_cur      <= old_cur_next;
    run          <= run_next;
    len          <= len_next;
    rng_lo       <= rng_lo_next;
    rng_last     <= rng_last_next;
    rng_set      <= rng_set_next;
    word_idx     <= word_idx_next;
    res_status   <= res_status_next;
    res_grant    <= res_grant_next;
    status       <= status_next;
    granted_page <= granted_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the bitmap page run allocator unit.
`timescale 1ns / 1ps

class page_run_ledger;
  localparam int unsigned MAP_PAGES = 65536;

  bit used_map[MAP_PAGES];
  int unsigned cursor;
  int unsigned page_limit;
  logic [bpra_pkg::STATUS_W-1:0] due_status[$];
  logic [bpra_pkg::GRANT_W-1:0] due_grant[$];
  int unsigned mismatches;

  function new();
    foreach (used_map[i]) used_map[i] = 1'b1;
    cursor = 0;
    page_limit = 0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return due_status.size();
  endfunction

  task report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Walk from the cursor towards lim looking for len free pages in a row.
  function bit find_run(input int unsigned len, input int unsigned lim,
                        output int unsigned first);
    int unsigned run;
    bit was_used;
    run = 0;
    first = 0;
    if (lim > MAP_PAGES) lim = MAP_PAGES;
    while (cursor < lim) begin
      was_used = used_map[cursor];
      cursor++;
      if (!was_used) begin
        run++;
        if (run == len) begin
          first = cursor - len;
          for (int unsigned p = first; p < cursor; p++) used_map[p] = 1'b1;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  function void note_request(input logic kind, input logic [bpra_pkg::START_W-1:0] first_page,
                             input logic [bpra_pkg::LEN_W-1:0] len);
    logic [bpra_pkg::STATUS_W-1:0] st;
    int unsigned grant;
    int unsigned saved;
    int unsigned stop;
    st = bpra_pkg::STATUS_OK;
    grant = 0;
    if (kind == bpra_pkg::REQ_ALLOC) begin
      saved = cursor;
      if (!find_run(32'(len), page_limit, grant)) begin
        // wrap to page 0 with a fresh count, up to the old cursor
        cursor = 0;
        if (!find_run(32'(len), saved, grant)) begin
          cursor = saved;
          grant = 0;
          st = bpra_pkg::STATUS_NO_RUN;
        end
      end
    end else begin
      stop = int'(first_page) + int'(len);
      for (int unsigned p = 32'(first_page); p < stop; p++) begin
        if (p >= MAP_PAGES) st = bpra_pkg::STATUS_RANGE;
        else used_map[p] = 1'b0;
      end
    end
    due_status.push_back(st);
    due_grant.push_back(grant[bpra_pkg::GRANT_W-1:0]);
  endfunction

  task check_result(input logic [bpra_pkg::STATUS_W-1:0] st,
                    input logic [bpra_pkg::GRANT_W-1:0] grant);
    logic [bpra_pkg::STATUS_W-1:0] want_st;
    logic [bpra_pkg::GRANT_W-1:0] want_grant;
    if (due_status.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d page %0d", st, grant));
    end else begin
      want_st = due_status.pop_front();
      want_grant = due_grant.pop_front();
      if (st !== want_st)
        report_mismatch($sformatf("status %0d, want %0d", st, want_st));
      if (grant !== want_grant)
        report_mismatch($sformatf("granted_page %0d, want %0d", grant, want_grant));
    end
  endtask
endclass

module testbench;
  localparam int unsigned MAP_PAGES = 65536;
  localparam int unsigned LEN_MAX = 131071;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [bpra_pkg::START_W-1:0] start_page;
  logic [bpra_pkg::LEN_W-1:0] run_length;
  logic out_valid;
  logic out_stall;
  logic [bpra_pkg::STATUS_W-1:0] status;
  logic [bpra_pkg::GRANT_W-1:0] granted_page;
  logic cfg_valid;
  logic cfg_ready;
  logic [bpra_pkg::LIMIT_W-1:0] cfg_data;

  page_run_ledger ledger;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned phase_limit[8] = '{512, 4096, 65536, 1000, 2048, 131071, 64, 3000};
  int unsigned phase_items[8] = '{260, 260, 80, 260, 260, 80, 260, 260};

  bitmap_page_run_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .start_page(start_page),
    .run_length(run_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_page(granted_page),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.check_result(status, granted_page);
  end

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 19;
        recv_idle_pct = 58;
      end
      1: begin
        send_idle_pct = 58;
        recv_idle_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bpra_pkg::LIMIT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ledger.page_limit = 32'(value);
  endtask

  task automatic issue(input logic kind, input logic [bpra_pkg::START_W-1:0] first_page,
                       input logic [bpra_pkg::LEN_W-1:0] len);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    start_page <= first_page;
    run_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(kind, first_page, len);
  endtask

  task automatic random_request(input int unsigned lim);
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(99, 0);
    top = (lim > MAP_PAGES) ? MAP_PAGES : lim;
    if (pick < 45)
      issue(bpra_pkg::REQ_ALLOC, 16'($urandom), 17'($urandom_range(24, 1)));
    else if (pick < 50)
      issue(bpra_pkg::REQ_ALLOC, 16'($urandom), 17'($urandom_range(200, 25)));
    else if (pick < 85)
      issue(bpra_pkg::REQ_FREE, 16'((top == 0) ? 0 : $urandom_range(top - 1, 0)),
            17'($urandom_range(32, 1)));
    else if (pick < 90)
      issue(bpra_pkg::REQ_FREE, 16'($urandom), 17'($urandom_range(64, 0)));
    else if (pick < 93)
      issue(bpra_pkg::REQ_ALLOC, 16'($urandom), 0);
    else if (pick < 96)
      issue(bpra_pkg::REQ_FREE, 16'($urandom_range(65535, 65500)),
            17'($urandom_range(100, 1)));
    else if (pick < 98)
      issue(bpra_pkg::REQ_FREE, 16'($urandom), 17'($urandom_range(LEN_MAX, 0)));
    else
      issue(bpra_pkg::REQ_ALLOC, 16'($urandom), 17'($urandom_range(LEN_MAX, 0)));
  endtask

  initial begin
    int unsigned lim;
    ledger = new();
    set_idling(0);
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= bpra_pkg::REQ_ALLOC;
    start_page <= '0;
    run_length <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // limit still at its reset value of zero, every page used
    issue(bpra_pkg::REQ_ALLOC, 0, 1);
    issue(bpra_pkg::REQ_FREE, 0, 0);
    issue(bpra_pkg::REQ_FREE, 16'hFFFF, 2);
    issue(bpra_pkg::REQ_FREE, 16'hFFFF, 17'(LEN_MAX));
    issue(bpra_pkg::REQ_ALLOC, 0, 0);

    write_limit(17'd65536);
    issue(bpra_pkg::REQ_ALLOC, 0, 1);
    issue(bpra_pkg::REQ_FREE, 0, 17'd65536);
    issue(bpra_pkg::REQ_ALLOC, 0, 17'd65536);
    issue(bpra_pkg::REQ_FREE, 16, 32);

    // above the page count, which acts as the page count
    write_limit(17'h1FFFF);
    issue(bpra_pkg::REQ_ALLOC, 0, 8);
    issue(bpra_pkg::REQ_ALLOC, 0, 40);

    write_limit(17'd64);
    issue(bpra_pkg::REQ_FREE, 0, 64);
    issue(bpra_pkg::REQ_FREE, 0, 64);
    issue(bpra_pkg::REQ_ALLOC, 0, 64);
    issue(bpra_pkg::REQ_ALLOC, 0, 30);
    issue(bpra_pkg::REQ_ALLOC, 0, 16);

    // cursor now sits above the limit
    write_limit(17'd8);
    issue(bpra_pkg::REQ_ALLOC, 0, 4);
    issue(bpra_pkg::REQ_FREE, 4, 4);
    issue(bpra_pkg::REQ_ALLOC, 0, 4);

    write_limit(17'd65535);
    issue(bpra_pkg::REQ_ALLOC, 16'hFFFF, 1);
    issue(bpra_pkg::REQ_FREE, 16'hAAAA, 17'h05555);
    issue(bpra_pkg::REQ_FREE, 16'h5555, 17'h0AAAA);

    for (int ph = 0; ph < 8; ph++) begin
      lim = phase_limit[ph];
      write_limit(lim[bpra_pkg::LIMIT_W-1:0]);
      set_idling(ph % 3);
      // release the whole searchable region so that allocations can succeed
      if (lim > 0) issue(bpra_pkg::REQ_FREE, 0, 17'((lim > MAP_PAGES) ? MAP_PAGES : lim));
      for (int k = 0; k < phase_items[ph]; k++) begin
        if ($urandom_range(99, 0) == 0) drain();
        random_request(lim);
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/bpra_pkg.sv
src/bpra_scan.sv
src/bitmap_page_run_allocator_unit.sv
tb/testbench.sv
